// ----- hw/rtl/rmf_pkg.sv -----
// ----------------------------------------------------------------------------
// rmf_pkg: shared definitions for the running median filter
// Window size, field widths and the command and status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rmf_pkg;

    // Window depth, 1 to 15.
    localparam int WINDOW   = 8;
    localparam int SLOT_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int COUNT_W  = $clog2(WINDOW + 1);

    localparam int SAMPLE_W = 16;
    localparam int MEDIAN_W = 17;
    localparam int FILLED_W = 4;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [MEDIAN_W-1:0] median_t;
    typedef logic        [FILLED_W-1:0] filled_t;
    typedef logic        [SLOT_W-1:0]   slot_t;
    typedef logic        [COUNT_W-1:0]  count_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;     // write the accepted sample and restart the scan
        logic scan;     // rank the current candidate entry
        logic publish;  // move the median into the output register
    } rmf_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;     // the current candidate is the last filled entry
    } rmf_status_t;

endpackage

// ----- hw/rtl/rmf_channels.sv -----
// ----------------------------------------------------------------------------
// rmf_channels: valid/ready channels of the running median filter
// One interface for the sample requests and one for the median results.
// ----------------------------------------------------------------------------
interface rmf_sample_if;
    import rmf_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface rmf_median_if;
    import rmf_pkg::*;

    logic    valid;
    logic    ready;
    median_t median_doubled;
    filled_t filled;

    modport source (output valid, output median_doubled, output filled, input ready);
    modport sink   (input valid, input median_doubled, input filled, output ready);
endinterface

// ----- hw/rtl/rmf_datapath.sv -----
// ----------------------------------------------------------------------------
// rmf_datapath: window store, rank scan and output register
// Each scan step compares one candidate entry against all filled entries and
// keeps it if its rank covers one of the two middle positions.
// ----------------------------------------------------------------------------
module rmf_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rmf_pkg::rmf_cmd_t    cmd,
    output rmf_pkg::rmf_status_t status,
    input  rmf_pkg::sample_t     sample,
    output rmf_pkg::median_t     median_doubled,
    output rmf_pkg::filled_t     filled
);
    import rmf_pkg::*;

    sample_t store_reg [WINDOW];
    slot_t   wslot_reg;
    count_t  fill_reg;
    slot_t   cand_reg;
    sample_t lo_val_reg;
    sample_t hi_val_reg;
    median_t median_reg;
    filled_t filled_reg;

    slot_t   wslot_next;
    count_t  fill_next;
    sample_t cand_val;
    count_t  less_cnt;
    count_t  equal_cnt;
    count_t  upper_cnt;
    count_t  lo_idx;
    count_t  hi_idx;
    logic    lo_hit;
    logic    hi_hit;

    always_comb
    begin
        wslot_next = (wslot_reg == slot_t'(WINDOW - 1)) ? '0 : wslot_reg + 1'b1;
        fill_next  = (fill_reg < count_t'(WINDOW)) ? fill_reg + 1'b1 : fill_reg;
    end

    // Rank of the candidate among the filled entries.
    always_comb
    begin
        cand_val  = store_reg[cand_reg];
        less_cnt  = '0;
        equal_cnt = '0;
        for (int j = 0; j < WINDOW; j++)
        begin
            if (count_t'(j) < fill_reg)
            begin
                less_cnt  = less_cnt  + count_t'(store_reg[j] <  cand_val);
                equal_cnt = equal_cnt + count_t'(store_reg[j] == cand_val);
            end
        end
        upper_cnt = less_cnt + equal_cnt;
        lo_idx    = (fill_reg - 1'b1) >> 1;
        hi_idx    = fill_reg >> 1;
        lo_hit    = (lo_idx >= less_cnt) && (lo_idx < upper_cnt);
        hi_hit    = (hi_idx >= less_cnt) && (hi_idx < upper_cnt);
    end

    assign status.last = (count_t'(cand_reg) == count_t'(fill_reg - 1'b1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wslot_reg <= '0;
            fill_reg  <= '0;
        end
        else if (cmd.load)
        begin
            wslot_reg <= wslot_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            store_reg[wslot_reg] <= sample;
            cand_reg             <= '0;
        end
        else if (cmd.scan)
        begin
            cand_reg <= cand_reg + 1'b1;
            if (lo_hit)
            begin
                lo_val_reg <= cand_val;
            end
            if (hi_hit)
            begin
                hi_val_reg <= cand_val;
            end
        end
        if (cmd.publish)
        begin
            median_reg <= MEDIAN_W'(lo_val_reg) + MEDIAN_W'(hi_val_reg);
            filled_reg <= FILLED_W'(fill_reg);
        end
    end

    assign median_doubled = median_reg;
    assign filled         = filled_reg;

endmodule

// ----- hw/rtl/rmf_controller.sv -----
// ----------------------------------------------------------------------------
// rmf_controller: sequencing of the running median filter
// Accepts a request, steps the rank scan over the filled entries and hands
// the median to the output register once that register is free.
// ----------------------------------------------------------------------------
module rmf_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output rmf_pkg::rmf_cmd_t    cmd,
    input  rmf_pkg::rmf_status_t status
);
    import rmf_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.scan    = 1'b0;
        cmd.publish = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.last)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- hw/rtl/running_median_filter.sv -----
// ----------------------------------------------------------------------------
// running_median_filter: sliding window median of signed distance samples
// Controller plus datapath; one median result for every sample request.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the samples channel carries one signed 16-bit sample.
//   It is written into an 8-entry ring buffer and the fill count grows up
//   to the window depth. One result follows on the medians channel: twice
//   the median of the filled entries (the sum of the two middle values for
//   an even count) and the number of entries it was taken over.
//   Sequence: the sample is written at the accepting edge; the rank scan
//   then steps over the n filled entries (one candidate entry per cycle,
//   compared against every filled entry at once) and, once the output
//   register is free, that register is loaded and the result is valid.
//   The controller passes through its idle state before it takes the next
//   request, so no request is taken while a scan or publish is pending. The
//   scan length is set by the single shared rank comparator row.
//   The output register decouples the two sides: a new request is accepted
//   while an earlier result still waits; if the receiver stalls, the next
//   result waits in the datapath until the output register is free.
//   Reset clears the fill count and write slot; the window restarts empty.
// ----------------------------------------------------------------------------
module running_median_filter (
    input  logic               clk,
    input  logic               rst_n,
    rmf_sample_if.sink         samples,
    rmf_median_if.source       medians
);
    import rmf_pkg::*;

    rmf_cmd_t    cmd;
    rmf_status_t status;

    rmf_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (medians.valid),
        .out_ready (medians.ready),
        .cmd       (cmd),
        .status    (status)
    );

    rmf_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .sample         (samples.sample),
        .median_doubled (medians.median_doubled),
        .filled         (medians.filled)
    );

    // A published median always shows up on the output in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.publish |=> medians.valid)
    else $error("published median not presented");

    // After a request is taken the block is busy scanning.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !samples.ready)
    else $error("request accepted during scan");

    // A result only appears after the controller loads the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(medians.valid) |-> $past(cmd.publish))
    else $error("result appeared without publish");

endmodule
